// ===== sv/srdc_pkg.sv =====
// shared types, constants and helpers for the damped-comb reverb
package srdc_pkg;

   localparam int SAMPLE_W   = 24;
   localparam int COEF_W     = 16;
   localparam int DELAY_W    = 11;
   localparam int NUM_COMBS  = 4;
   localparam int COMB_SEL_W = $clog2(NUM_COMBS);
   localparam int COMB_DEPTH = 2048;
   localparam int COMB_AW    = $clog2(COMB_DEPTH);
   localparam int AP1_DELAY  = 220;
   localparam int AP1_SIZE   = 256;
   localparam int AP1_AW     = $clog2(AP1_SIZE);
   localparam int AP2_DELAY  = 74;
   localparam int AP2_SIZE   = 128;
   localparam int AP2_AW     = $clog2(AP2_SIZE);

   localparam int CLEAR_LEN  = (COMB_DEPTH > AP1_SIZE) ? COMB_DEPTH : AP1_SIZE;
   localparam int CLR_W      = $clog2(CLEAR_LEN);

   localparam int OP_W       = SAMPLE_W + 1;
   localparam int PROD_W     = OP_W + COEF_W + 1;
   localparam int RES_W      = PROD_W - COEF_W;
   localparam int WIDE_W     = RES_W + 1;
   localparam int ACC_W      = SAMPLE_W + COMB_SEL_W;

   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 16;

   localparam logic [CSR_IDX_W-1:0] CSR_COMB_DELAY_0 = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_COMB_DELAY_1 = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_COMB_DELAY_2 = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_COMB_DELAY_3 = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_COMB_FEEDBACK = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_DAMPING_COEF = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_ALLPASS_GAIN = 3'd6;

   localparam logic [DELAY_W-1:0] RST_COMB_DELAY_0 = 11'd1309;
   localparam logic [DELAY_W-1:0] RST_COMB_DELAY_1 = 11'd1636;
   localparam logic [DELAY_W-1:0] RST_COMB_DELAY_2 = 11'd1812;
   localparam logic [DELAY_W-1:0] RST_COMB_DELAY_3 = 11'd1927;
   localparam logic [COEF_W-1:0]  RST_COMB_FEEDBACK = 16'd55705;
   localparam logic [COEF_W-1:0]  RST_DAMPING_COEF = 16'd23791;
   localparam logic [COEF_W-1:0]  RST_ALLPASS_GAIN = 16'd32768;

   localparam logic [AP1_AW-1:0] AP1_OFFSET = AP1_AW'(AP1_DELAY % AP1_SIZE);
   localparam logic [AP2_AW-1:0] AP2_OFFSET = AP2_AW'(AP2_DELAY % AP2_SIZE);

   typedef logic signed [SAMPLE_W-1:0] sample_type;
   typedef logic signed [OP_W-1:0]     mul_op_type;
   typedef logic signed [RES_W-1:0]    mul_res_type;
   typedef logic signed [WIDE_W-1:0]   wide_type;
   typedef logic signed [ACC_W-1:0]    acc_type;
   typedef logic [COEF_W-1:0]          coef_type;
   typedef logic [DELAY_W-1:0]         delay_type;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_LP,
      ST_LPW,
      ST_FB,
      ST_WR,
      ST_AVG,
      ST_A1_MUL,
      ST_A1_OUT,
      ST_A1_WR,
      ST_A2_OUT,
      ST_A2_WR,
      ST_DONE
   } srdc_state_type;

   localparam wide_type WIDE_SMAX = wide_type'((64'sd1 <<< (SAMPLE_W - 1)) - 64'sd1);
   localparam wide_type WIDE_SMIN = wide_type'(-(64'sd1 <<< (SAMPLE_W - 1)));

   // clamp to the signed sample range
   function automatic sample_type sat_sample(input wide_type v);
      sample_type r;
      if (v > WIDE_SMAX) begin
         r = WIDE_SMAX[SAMPLE_W-1:0];
      end else if (v < WIDE_SMIN) begin
         r = WIDE_SMIN[SAMPLE_W-1:0];
      end else begin
         r = v[SAMPLE_W-1:0];
      end
      return r;
   endfunction

endpackage

// ===== sv/srdc_req_if.sv =====
// input sample channel
interface srdc_req_if;
   logic                   valid;
   logic                   ready;
   srdc_pkg::sample_type   sample_in;

   modport source (output valid, output sample_in, input ready);
   modport sink (input valid, input sample_in, output ready);
endinterface

// ===== sv/srdc_rsp_if.sv =====
// output sample channel
interface srdc_rsp_if;
   logic                   valid;
   logic                   ready;
   srdc_pkg::sample_type   sample_out;

   modport source (output valid, output sample_out, input ready);
   modport sink (input valid, input sample_out, output ready);
endinterface

// ===== sv/srdc_qmul.sv =====
// shared signed-by-q0.16 multiplier with round-half-up and output register
module srdc_qmul (
   input  logic                  clock,
   input  srdc_pkg::mul_op_type  op_a,
   input  srdc_pkg::coef_type    coef,
   output srdc_pkg::mul_res_type product_ff
);

   logic signed [srdc_pkg::PROD_W-1:0] prod;
   logic signed [srdc_pkg::PROD_W-1:0] rounded;
   srdc_pkg::mul_res_type              product_in;

   always_comb begin
      prod = srdc_pkg::PROD_W'(op_a)
           * srdc_pkg::PROD_W'($signed({1'b0, coef}));
      rounded = prod + srdc_pkg::PROD_W'(1 << (srdc_pkg::COEF_W - 1));
      product_in = rounded[srdc_pkg::PROD_W-1:srdc_pkg::COEF_W];
   end

   always_ff @(posedge clock) begin
      product_ff <= product_in;
   end

endmodule

// ===== sv/schroeder_reverb_damped_comb.sv =====
// damped-comb schroeder reverb top level: four combs, two allpass stages
// one input transfer yields one result; a new transfer is taken only after the
// previous result is loaded into the output register, so one sample is in work at a time
// all multiplies go through one registered multiplier under a small sequencer
// after reset a clearing pass zeroes the delay memories, no input is taken
// meanwhile; configuration writes are taken at any time
module schroeder_reverb_damped_comb (
   input  logic                               clock,
   input  logic                               reset,
   srdc_req_if.sink                           req_chan,
   srdc_rsp_if.source                         rsp_chan,
   input  logic                               csr_we,
   input  logic [srdc_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [srdc_pkg::CSR_DATA_W-1:0]    csr_wdata
);

   srdc_pkg::srdc_state_type state_ff, state_in;

   logic [srdc_pkg::CLR_W-1:0]      clr_cnt_ff, clr_cnt_in;
   logic [srdc_pkg::COMB_SEL_W-1:0] comb_sel_ff, comb_sel_in;
   logic [srdc_pkg::COMB_AW-1:0]    wp_ff, wp_in;
   logic [srdc_pkg::AP1_AW-1:0]     ap1_ptr_ff, ap1_ptr_in;
   logic [srdc_pkg::AP2_AW-1:0]     ap2_ptr_ff, ap2_ptr_in;

   srdc_pkg::delay_type comb_delay_ff [srdc_pkg::NUM_COMBS];
   srdc_pkg::delay_type comb_delay_in [srdc_pkg::NUM_COMBS];
   srdc_pkg::coef_type  feedback_ff, feedback_in;
   srdc_pkg::coef_type  damping_ff, damping_in;
   srdc_pkg::coef_type  ap_gain_ff, ap_gain_in;

   srdc_pkg::sample_type damp_ff [srdc_pkg::NUM_COMBS];
   srdc_pkg::sample_type damp_in [srdc_pkg::NUM_COMBS];
   srdc_pkg::sample_type x_ff, x_in;
   srdc_pkg::acc_type    acc_ff, acc_in;
   srdc_pkg::sample_type avg_ff, avg_in;
   srdc_pkg::sample_type ap1_out_ff, ap1_out_in;
   srdc_pkg::sample_type result_ff, result_in;
   srdc_pkg::sample_type rsp_data_ff, rsp_data_in;
   logic                 rsp_valid_ff, rsp_valid_in;

   // control
   logic                 req_xfer;
   logic                 mem_rd_en;
   logic                 clearing;
   logic                 comb_wr;
   logic                 ap1_wr;
   logic                 ap2_wr;
   logic                 rsp_load;

   // datapath
   srdc_pkg::sample_type  comb_rd [srdc_pkg::NUM_COMBS];
   srdc_pkg::sample_type  ap1_rd_ff;
   srdc_pkg::sample_type  ap2_rd_ff;
   srdc_pkg::sample_type  delayed_sel;
   srdc_pkg::sample_type  damp_sel;
   srdc_pkg::mul_op_type  mul_a;
   srdc_pkg::coef_type    mul_c;
   srdc_pkg::mul_res_type mul_res_ff;
   srdc_pkg::wide_type    mul_wide;
   srdc_pkg::acc_type     avg_sum;

   logic [srdc_pkg::COMB_AW-1:0] comb_wr_addr;
   srdc_pkg::sample_type         comb_wr_data;
   srdc_pkg::sample_type         comb_wr_val;
   logic [srdc_pkg::AP1_AW-1:0]  ap1_wr_addr;
   logic [srdc_pkg::AP1_AW-1:0]  ap1_rd_addr;
   srdc_pkg::sample_type         ap1_wr_data;
   logic [srdc_pkg::AP2_AW-1:0]  ap2_wr_addr;
   logic [srdc_pkg::AP2_AW-1:0]  ap2_rd_addr;
   srdc_pkg::sample_type         ap2_wr_data;

   assign req_xfer = req_chan.valid && req_chan.ready;
   assign rsp_chan.valid = rsp_valid_ff;
   assign rsp_chan.sample_out = rsp_data_ff;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         srdc_pkg::ST_CLEAR: begin
            if (clr_cnt_ff == srdc_pkg::CLR_W'(srdc_pkg::CLEAR_LEN - 1)) begin
               state_in = srdc_pkg::ST_IDLE;
            end
         end
         srdc_pkg::ST_IDLE: begin
            if (req_chan.valid) begin
               state_in = srdc_pkg::ST_LP;
            end
         end
         srdc_pkg::ST_LP:     state_in = srdc_pkg::ST_LPW;
         srdc_pkg::ST_LPW:    state_in = srdc_pkg::ST_FB;
         srdc_pkg::ST_FB:     state_in = srdc_pkg::ST_WR;
         srdc_pkg::ST_WR: begin
            if (comb_sel_ff == srdc_pkg::COMB_SEL_W'(srdc_pkg::NUM_COMBS - 1)) begin
               state_in = srdc_pkg::ST_AVG;
            end else begin
               state_in = srdc_pkg::ST_LP;
            end
         end
         srdc_pkg::ST_AVG:    state_in = srdc_pkg::ST_A1_MUL;
         srdc_pkg::ST_A1_MUL: state_in = srdc_pkg::ST_A1_OUT;
         srdc_pkg::ST_A1_OUT: state_in = srdc_pkg::ST_A1_WR;
         srdc_pkg::ST_A1_WR:  state_in = srdc_pkg::ST_A2_OUT;
         srdc_pkg::ST_A2_OUT: state_in = srdc_pkg::ST_A2_WR;
         srdc_pkg::ST_A2_WR:  state_in = srdc_pkg::ST_DONE;
         srdc_pkg::ST_DONE: begin
            if (!rsp_valid_ff || rsp_chan.ready) begin
               state_in = srdc_pkg::ST_IDLE;
            end
         end
         default:             state_in = srdc_pkg::ST_CLEAR;
      endcase
   end

   // sequencer outputs
   always_comb begin
      req_chan.ready = 1'b0;
      clearing = 1'b0;
      comb_wr = 1'b0;
      ap1_wr = 1'b0;
      ap2_wr = 1'b0;
      rsp_load = 1'b0;
      mul_a = '0;
      mul_c = '0;
      case (state_ff)
         srdc_pkg::ST_CLEAR: clearing = 1'b1;
         srdc_pkg::ST_IDLE:  req_chan.ready = 1'b1;
         srdc_pkg::ST_LP: begin
            mul_a = srdc_pkg::OP_W'(delayed_sel) - srdc_pkg::OP_W'(damp_sel);
            mul_c = damping_ff;
         end
         srdc_pkg::ST_FB: begin
            mul_a = srdc_pkg::OP_W'(damp_sel);
            mul_c = feedback_ff;
         end
         srdc_pkg::ST_WR: comb_wr = 1'b1;
         srdc_pkg::ST_A1_MUL: begin
            mul_a = srdc_pkg::OP_W'(avg_ff);
            mul_c = ap_gain_ff;
         end
         srdc_pkg::ST_A1_OUT: begin
            mul_a = srdc_pkg::OP_W'(ap1_rd_ff);
            mul_c = ap_gain_ff;
         end
         srdc_pkg::ST_A1_WR: begin
            ap1_wr = 1'b1;
            mul_a = srdc_pkg::OP_W'(ap1_out_ff);
            mul_c = ap_gain_ff;
         end
         srdc_pkg::ST_A2_OUT: begin
            mul_a = srdc_pkg::OP_W'(ap2_rd_ff);
            mul_c = ap_gain_ff;
         end
         srdc_pkg::ST_A2_WR: ap2_wr = 1'b1;
         srdc_pkg::ST_DONE:  rsp_load = !rsp_valid_ff || rsp_chan.ready;
         default: begin
            mul_a = '0;
            mul_c = '0;
         end
      endcase
   end

   assign mem_rd_en = req_xfer;

   srdc_qmul u_qmul (
      .clock      (clock),
      .op_a       (mul_a),
      .coef       (mul_c),
      .product_ff (mul_res_ff)
   );

   // datapath and register next values
   always_comb begin
      delayed_sel = comb_rd[comb_sel_ff];
      damp_sel = damp_ff[comb_sel_ff];
      mul_wide = srdc_pkg::WIDE_W'(mul_res_ff);
      avg_sum = acc_ff + srdc_pkg::ACC_W'(2);
      comb_wr_val = srdc_pkg::sat_sample(srdc_pkg::WIDE_W'(x_ff) + mul_wide);

      clr_cnt_in = clearing ? clr_cnt_ff + 1'b1 : clr_cnt_ff;
      comb_sel_in = comb_sel_ff;
      wp_in = wp_ff;
      ap1_ptr_in = ap1_ptr_ff;
      ap2_ptr_in = ap2_ptr_ff;
      damp_in = damp_ff;
      x_in = x_ff;
      acc_in = acc_ff;
      avg_in = avg_ff;
      ap1_out_in = ap1_out_ff;
      result_in = result_ff;
      rsp_data_in = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff;

      if (req_xfer) begin
         x_in = req_chan.sample_in;
         acc_in = '0;
         comb_sel_in = '0;
      end
      if (state_ff == srdc_pkg::ST_LPW) begin
         damp_in[comb_sel_ff] =
            srdc_pkg::sat_sample(srdc_pkg::WIDE_W'(damp_sel) + mul_wide);
      end
      if (comb_wr) begin
         acc_in = acc_ff + srdc_pkg::ACC_W'(delayed_sel);
         comb_sel_in = comb_sel_ff + 1'b1;
      end
      if (state_ff == srdc_pkg::ST_AVG) begin
         avg_in = avg_sum[srdc_pkg::ACC_W-1:srdc_pkg::COMB_SEL_W];
         wp_in = wp_ff + 1'b1;
      end
      if (state_ff == srdc_pkg::ST_A1_OUT) begin
         ap1_out_in = srdc_pkg::sat_sample(srdc_pkg::WIDE_W'(ap1_rd_ff) - mul_wide);
      end
      if (ap1_wr) begin
         ap1_ptr_in = ap1_ptr_ff + 1'b1;
      end
      if (state_ff == srdc_pkg::ST_A2_OUT) begin
         result_in = srdc_pkg::sat_sample(srdc_pkg::WIDE_W'(ap2_rd_ff) - mul_wide);
      end
      if (ap2_wr) begin
         ap2_ptr_in = ap2_ptr_ff + 1'b1;
      end
      if (rsp_load) begin
         rsp_data_in = result_ff;
         rsp_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // configuration writes
   always_comb begin
      comb_delay_in = comb_delay_ff;
      feedback_in = feedback_ff;
      damping_in = damping_ff;
      ap_gain_in = ap_gain_ff;
      if (csr_we) begin
         case (csr_index)
            srdc_pkg::CSR_COMB_DELAY_0:  comb_delay_in[0] = csr_wdata[srdc_pkg::DELAY_W-1:0];
            srdc_pkg::CSR_COMB_DELAY_1:  comb_delay_in[1] = csr_wdata[srdc_pkg::DELAY_W-1:0];
            srdc_pkg::CSR_COMB_DELAY_2:  comb_delay_in[2] = csr_wdata[srdc_pkg::DELAY_W-1:0];
            srdc_pkg::CSR_COMB_DELAY_3:  comb_delay_in[3] = csr_wdata[srdc_pkg::DELAY_W-1:0];
            srdc_pkg::CSR_COMB_FEEDBACK: feedback_in = csr_wdata[srdc_pkg::COEF_W-1:0];
            srdc_pkg::CSR_DAMPING_COEF:  damping_in = csr_wdata[srdc_pkg::COEF_W-1:0];
            srdc_pkg::CSR_ALLPASS_GAIN:  ap_gain_in = csr_wdata[srdc_pkg::COEF_W-1:0];
            default:                     feedback_in = feedback_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= srdc_pkg::ST_CLEAR;
         clr_cnt_ff <= '0;
         comb_sel_ff <= '0;
         wp_ff <= '0;
         ap1_ptr_ff <= '0;
         ap2_ptr_ff <= '0;
         comb_delay_ff[0] <= srdc_pkg::RST_COMB_DELAY_0;
         comb_delay_ff[1] <= srdc_pkg::RST_COMB_DELAY_1;
         comb_delay_ff[2] <= srdc_pkg::RST_COMB_DELAY_2;
         comb_delay_ff[3] <= srdc_pkg::RST_COMB_DELAY_3;
         feedback_ff <= srdc_pkg::RST_COMB_FEEDBACK;
         damping_ff <= srdc_pkg::RST_DAMPING_COEF;
         ap_gain_ff <= srdc_pkg::RST_ALLPASS_GAIN;
         for (int i = 0; i < srdc_pkg::NUM_COMBS; i++) begin
            damp_ff[i] <= '0;
         end
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         clr_cnt_ff <= clr_cnt_in;
         comb_sel_ff <= comb_sel_in;
         wp_ff <= wp_in;
         ap1_ptr_ff <= ap1_ptr_in;
         ap2_ptr_ff <= ap2_ptr_in;
         comb_delay_ff <= comb_delay_in;
         feedback_ff <= feedback_in;
         damping_ff <= damping_in;
         ap_gain_ff <= ap_gain_in;
         damp_ff <= damp_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      x_ff <= x_in;
      acc_ff <= acc_in;
      avg_ff <= avg_in;
      ap1_out_ff <= ap1_out_in;
      result_ff <= result_in;
      rsp_data_ff <= rsp_data_in;
   end

   // comb delay memories, one per comb
   assign comb_wr_addr = clearing ? clr_cnt_ff[srdc_pkg::COMB_AW-1:0] : wp_ff;
   assign comb_wr_data = clearing ? '0 : comb_wr_val;

   for (genvar b = 0; b < srdc_pkg::NUM_COMBS; b++) begin : g_comb
      srdc_pkg::sample_type         mem [srdc_pkg::COMB_DEPTH];
      srdc_pkg::sample_type         rd_ff;
      logic [srdc_pkg::COMB_AW-1:0] rd_addr;
      logic                         we;

      assign rd_addr = wp_ff - srdc_pkg::COMB_AW'(comb_delay_ff[b]);
      assign we = clearing
               || (comb_wr && (comb_sel_ff == srdc_pkg::COMB_SEL_W'(b)));
      assign comb_rd[b] = rd_ff;

      always_ff @(posedge clock) begin
         if (we) begin
            mem[comb_wr_addr] <= comb_wr_data;
         end
         if (mem_rd_en) begin
            rd_ff <= mem[rd_addr];
         end
      end
   end

   // allpass delay memories
   srdc_pkg::sample_type ap1_mem [srdc_pkg::AP1_SIZE];
   srdc_pkg::sample_type ap2_mem [srdc_pkg::AP2_SIZE];

   assign ap1_rd_addr = ap1_ptr_ff - srdc_pkg::AP1_OFFSET;
   assign ap2_rd_addr = ap2_ptr_ff - srdc_pkg::AP2_OFFSET;
   assign ap1_wr_addr = clearing ? clr_cnt_ff[srdc_pkg::AP1_AW-1:0] : ap1_ptr_ff;
   assign ap2_wr_addr = clearing ? clr_cnt_ff[srdc_pkg::AP2_AW-1:0] : ap2_ptr_ff;
   assign ap1_wr_data = clearing ? '0
                      : srdc_pkg::sat_sample(srdc_pkg::WIDE_W'(avg_ff) + mul_wide);
   assign ap2_wr_data = clearing ? '0
                      : srdc_pkg::sat_sample(srdc_pkg::WIDE_W'(ap1_out_ff) + mul_wide);

   always_ff @(posedge clock) begin
      if (clearing || ap1_wr) begin
         ap1_mem[ap1_wr_addr] <= ap1_wr_data;
      end
      if (mem_rd_en) begin
         ap1_rd_ff <= ap1_mem[ap1_rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (clearing || ap2_wr) begin
         ap2_mem[ap2_wr_addr] <= ap2_wr_data;
      end
      if (mem_rd_en) begin
         ap2_rd_ff <= ap2_mem[ap2_rd_addr];
      end
   end

endmodule

// ===== test/srdc_checker.sv =====
// watches the reverb channels, predicts each output sample and compares it
`timescale 1ns / 1ps

module srdc_checker (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   input  logic                            req_ready,
   input  srdc_pkg::sample_type            req_sample_in,
   input  logic                            rsp_valid,
   input  logic                            rsp_ready,
   input  srdc_pkg::sample_type            rsp_sample_out,
   input  logic                            csr_we,
   input  logic [srdc_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [srdc_pkg::CSR_DATA_W-1:0] csr_wdata,
   output int                              mismatches,
   output int                              outstanding
);
   import srdc_pkg::*;

   localparam longint SAMPLE_MAX = (64'sd1 <<< (SAMPLE_W - 1)) - 64'sd1;
   localparam longint SAMPLE_MIN = -(64'sd1 <<< (SAMPLE_W - 1));

   delay_type            comb_delay [NUM_COMBS];
   coef_type             feedback_gain;
   coef_type             lowpass_coef;
   coef_type             diffuse_gain;

   sample_type           comb_line [NUM_COMBS][COMB_DEPTH];
   logic [COMB_AW-1:0]   comb_wr;
   sample_type           lowpass_y [NUM_COMBS];
   sample_type           ap1_line [AP1_SIZE];
   logic [AP1_AW-1:0]    ap1_wr;
   sample_type           ap2_line [AP2_SIZE];
   logic [AP2_AW-1:0]    ap2_wr;

   sample_type           pending_samples [$];
   int                   fail_total;
   int                   result_count;

   function automatic longint clamp_sample(input longint v);
      if (v > SAMPLE_MAX) return SAMPLE_MAX;
      if (v < SAMPLE_MIN) return SAMPLE_MIN;
      return v;
   endfunction

   // q0.16 product rounded to nearest, ties upward
   function automatic longint mul_q16(input longint x, input coef_type c);
      return (x * longint'(c) + 64'sd32768) >>> 16;
   endfunction

   function automatic sample_type reverb_sample(input sample_type dry);
      longint             mix;
      longint             tap;
      longint             y;
      longint             ap1_tap;
      longint             ap1_out;
      longint             ap2_tap;
      longint             ap2_out;
      logic [COMB_AW-1:0] rd;
      logic [AP1_AW-1:0]  rd1;
      logic [AP2_AW-1:0]  rd2;
      mix = 0;
      for (int c = 0; c < NUM_COMBS; c++) begin
         rd = comb_wr - comb_delay[c];
         tap = longint'(comb_line[c][rd]);
         y = longint'(lowpass_y[c]);
         y = clamp_sample(y + mul_q16(tap - y, lowpass_coef));
         lowpass_y[c] = sample_type'(y);
         comb_line[c][comb_wr] =
            sample_type'(clamp_sample(longint'(dry) + mul_q16(y, feedback_gain)));
         mix = mix + tap;
      end
      comb_wr = comb_wr + 1'b1;
      mix = clamp_sample((mix + 2) >>> 2);

      rd1 = ap1_wr - AP1_OFFSET;
      ap1_tap = longint'(ap1_line[rd1]);
      ap1_out = clamp_sample(ap1_tap - mul_q16(mix, diffuse_gain));
      ap1_line[ap1_wr] = sample_type'(clamp_sample(mix + mul_q16(ap1_tap, diffuse_gain)));
      ap1_wr = ap1_wr + 1'b1;

      rd2 = ap2_wr - AP2_OFFSET;
      ap2_tap = longint'(ap2_line[rd2]);
      ap2_out = clamp_sample(ap2_tap - mul_q16(ap1_out, diffuse_gain));
      ap2_line[ap2_wr] = sample_type'(clamp_sample(ap1_out + mul_q16(ap2_tap, diffuse_gain)));
      ap2_wr = ap2_wr + 1'b1;

      return sample_type'(ap2_out);
   endfunction

   always @(posedge clock) begin
      sample_type want;
      if (reset) begin
         comb_delay[0] = RST_COMB_DELAY_0;
         comb_delay[1] = RST_COMB_DELAY_1;
         comb_delay[2] = RST_COMB_DELAY_2;
         comb_delay[3] = RST_COMB_DELAY_3;
         feedback_gain = RST_COMB_FEEDBACK;
         lowpass_coef = RST_DAMPING_COEF;
         diffuse_gain = RST_ALLPASS_GAIN;
         foreach (comb_line[c, k]) comb_line[c][k] = '0;
         foreach (lowpass_y[c]) lowpass_y[c] = '0;
         foreach (ap1_line[k]) ap1_line[k] = '0;
         foreach (ap2_line[k]) ap2_line[k] = '0;
         comb_wr = '0;
         ap1_wr = '0;
         ap2_wr = '0;
         pending_samples.delete();
         outstanding <= 0;
      end else begin
         if (csr_we) begin
            case (csr_index)
               CSR_COMB_DELAY_0: comb_delay[0] = csr_wdata[DELAY_W-1:0];
               CSR_COMB_DELAY_1: comb_delay[1] = csr_wdata[DELAY_W-1:0];
               CSR_COMB_DELAY_2: comb_delay[2] = csr_wdata[DELAY_W-1:0];
               CSR_COMB_DELAY_3: comb_delay[3] = csr_wdata[DELAY_W-1:0];
               CSR_COMB_FEEDBACK: feedback_gain = csr_wdata;
               CSR_DAMPING_COEF: lowpass_coef = csr_wdata;
               CSR_ALLPASS_GAIN: diffuse_gain = csr_wdata;
               default: ;
            endcase
         end
         if (req_valid && req_ready) begin
            pending_samples.insert(pending_samples.size(), reverb_sample(req_sample_in));
         end
         if (rsp_valid && rsp_ready) begin
            if (pending_samples.size() == 0) begin
               if (fail_total < 10) begin
                  $display("unexpected result %0d: sample_out %0d", result_count,
                           rsp_sample_out);
               end
               fail_total = fail_total + 1;
            end else begin
               want = pending_samples.pop_front();
               if (rsp_sample_out !== want) begin
                  if (fail_total < 10) begin
                     $display("result %0d sample_out mismatch: expected %0d, actual %0d",
                              result_count, want, rsp_sample_out);
                  end
                  fail_total = fail_total + 1;
               end
            end
            result_count = result_count + 1;
         end
         outstanding <= pending_samples.size();
      end
      mismatches <= fail_total;
   end

endmodule

// ===== test/tb_schroeder_reverb_damped_comb.sv =====
// stimulus, handshake pacing and verdict for the damped-comb reverb
`timescale 1ns / 1ps

module tb_schroeder_reverb_damped_comb;
   import srdc_pkg::*;

   localparam logic [CSR_IDX_W-1:0] CSR_UNMAPPED = 3'd7;
   localparam sample_type SAMPLE_HI = {1'b0, {(SAMPLE_W-1){1'b1}}};
   localparam sample_type SAMPLE_LO = {1'b1, {(SAMPLE_W-1){1'b0}}};
   localparam int SETTLE_CYCLES  = 40;
   localparam int HOLD_CYCLES    = 600;
   localparam int WATCHDOG_LIMIT = 20000;

   typedef enum int {RX_OPEN, RX_COIN, RX_SPARSE, RX_MOSTLY} rx_mode_type;

   logic                   clock = 1'b0;
   logic                   reset;
   logic                   csr_we;
   logic [CSR_IDX_W-1:0]   csr_index;
   logic [CSR_DATA_W-1:0]  csr_wdata;
   logic                   squeeze_rsp;
   int                     mismatches;
   int                     outstanding;
   int                     quiet_cycles;
   sample_type             directed_q [$];

   srdc_req_if req_chan ();
   srdc_rsp_if rsp_chan ();

   schroeder_reverb_damped_comb u_top (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .rsp_chan  (rsp_chan),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   srdc_checker u_checker (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_chan.valid),
      .req_ready      (req_chan.ready),
      .req_sample_in  (req_chan.sample_in),
      .rsp_valid      (rsp_chan.valid),
      .rsp_ready      (rsp_chan.ready),
      .rsp_sample_out (rsp_chan.sample_out),
      .csr_we         (csr_we),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .mismatches     (mismatches),
      .outstanding    (outstanding)
   );

   always #2 clock = ~clock;

   function automatic sample_type pick_sample(input bit loud);
      int roll;
      roll = $urandom_range(0, 9);
      if (roll < (loud ? 6 : 2)) begin
         case ($urandom_range(0, 3))
            0: return SAMPLE_HI;
            1: return SAMPLE_LO;
            2: return '0;
            default: return '1;
         endcase
      end
      if (roll < (loud ? 7 : 4)) return sample_type'(int'($urandom_range(0, 8191)) - 4096);
      return sample_type'($urandom());
   endfunction

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] val);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
   endtask

   task automatic set_reverb(input logic [CSR_DATA_W-1:0] d0, input logic [CSR_DATA_W-1:0] d1,
                             input logic [CSR_DATA_W-1:0] d2, input logic [CSR_DATA_W-1:0] d3,
                             input logic [CSR_DATA_W-1:0] fb, input logic [CSR_DATA_W-1:0] damp,
                             input logic [CSR_DATA_W-1:0] gain);
      write_reg(CSR_COMB_DELAY_0, d0);
      write_reg(CSR_COMB_DELAY_1, d1);
      write_reg(CSR_COMB_DELAY_2, d2);
      write_reg(CSR_COMB_DELAY_3, d3);
      write_reg(CSR_COMB_FEEDBACK, fb);
      write_reg(CSR_DAMPING_COEF, damp);
      write_reg(CSR_ALLPASS_GAIN, gain);
      // unmapped index must leave every setting alone
      write_reg(CSR_UNMAPPED, CSR_DATA_W'($urandom()));
      csr_we <= 1'b0;
   endtask

   task automatic send_one(input sample_type s);
      req_chan.valid <= 1'b1;
      req_chan.sample_in <= s;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
   endtask

   task automatic run_items(input int count, input bit loud);
      int burst_left;
      int gap;
      burst_left = $urandom_range(1, 24);
      for (int n = 0; n < count; n++) begin
         send_one(pick_sample(loud));
         burst_left = burst_left - 1;
         if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 60);
            if (gap > 0) begin
               req_chan.valid <= 1'b0;
               repeat (gap) @(posedge clock);
            end
         end
      end
      req_chan.valid <= 1'b0;
   endtask

   task automatic drain();
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // receiver stall pattern, with one long hold-off on request
   initial begin
      rx_mode_type mode;
      int          mode_left;
      bit          squeezed;
      rsp_chan.ready = 1'b0;
      mode = RX_OPEN;
      mode_left = 0;
      squeezed = 1'b0;
      forever begin
         @(posedge clock);
         if (squeeze_rsp && !squeezed) begin
            squeezed = 1'b1;
            rsp_chan.ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end else begin
            if (mode_left == 0) begin
               mode = rx_mode_type'($urandom_range(0, 3));
               mode_left = $urandom_range(20, 200);
            end
            mode_left = mode_left - 1;
            case (mode)
               RX_OPEN: rsp_chan.ready <= 1'b1;
               RX_COIN: rsp_chan.ready <= 1'($urandom_range(0, 1));
               RX_SPARSE: rsp_chan.ready <= ($urandom_range(0, 3) == 0);
               default: rsp_chan.ready <= ($urandom_range(0, 7) != 0);
            endcase
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("Verification failed");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      reset = 1'b1;
      csr_we = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      squeeze_rsp = 1'b0;
      req_chan.valid = 1'b0;
      req_chan.sample_in = '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // short delays, zero delay on the last comb, junk above the delay bits, full gains
      set_reverb(16'hF801, 16'h0002, 16'h0803, 16'h0000, 16'hFFFF, 16'hFFFF, 16'hFFFF);
      directed_q = '{SAMPLE_HI, SAMPLE_HI, SAMPLE_HI, SAMPLE_HI, SAMPLE_HI,
                     SAMPLE_LO, SAMPLE_LO, SAMPLE_LO, SAMPLE_LO, SAMPLE_LO,
                     '0, '0, '1, sample_type'(1), sample_type'(24'h555555),
                     sample_type'(24'hAAAAAA), SAMPLE_HI, SAMPLE_LO, SAMPLE_HI, SAMPLE_LO,
                     '0, '0};
      foreach (directed_q[k]) send_one(directed_q[k]);
      req_chan.valid <= 1'b0;
      drain();

      set_reverb(16'($urandom_range(1, 64)), 16'($urandom_range(1, 64)),
                 16'($urandom_range(1, 64)), 16'($urandom_range(1, 64)),
                 16'($urandom()), 16'($urandom()), 16'($urandom()));
      squeeze_rsp <= 1'b1;
      run_items(210, 1'b0);
      drain();

      set_reverb(16'h07FF, 16'h07FF, 16'h07FF, 16'h07FF, 16'h0000, 16'h0000, 16'h0000);
      run_items(200, 1'b0);
      drain();

      set_reverb(16'($urandom_range(1, 32)), 16'($urandom_range(1, 32)),
                 16'($urandom_range(1, 32)), 16'($urandom_range(1, 32)),
                 16'hFFFF, 16'hFFFF, 16'hFFFF);
      run_items(210, 1'b1);
      drain();

      set_reverb({5'($urandom()), 11'd0}, {5'($urandom()), 11'd0},
                 {5'($urandom()), 11'd0}, {5'($urandom()), 11'd0},
                 16'($urandom()), 16'($urandom()), 16'($urandom()));
      run_items(210, 1'b0);
      drain();

      set_reverb(16'($urandom()), 16'($urandom()), 16'($urandom()), 16'($urandom()),
                 16'($urandom()), 16'($urandom()), 16'($urandom()));
      run_items(220, 1'b0);
      drain();

      set_reverb(16'(RST_COMB_DELAY_0), 16'(RST_COMB_DELAY_1), 16'(RST_COMB_DELAY_2),
                 16'(RST_COMB_DELAY_3), RST_COMB_FEEDBACK, RST_DAMPING_COEF,
                 RST_ALLPASS_GAIN);
      run_items(220, 1'b0);
      drain();

      if (mismatches == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
